/* hdl/lsl_pkg.sv */
// Shared types, constants and tables of the slip traction pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package lsl_pkg;

    // Square root: 32 restoring iterations, two per pipeline stage.
    localparam int ROOT_PER_STAGE = 2;
    localparam int ROOT_STAGES    = 16;

    // Quotient bits of the pressure ratio and exponent table length.
    localparam int DIV_STEPS = 21;
    localparam int EXP_BITS  = 21;

    // Datapath widths.
    localparam int CW    = 36;
    localparam int ZW    = 33;
    localparam int NUM_W = 56;

    localparam logic [30:0] SAT31         = 31'h7FFF_FFFF;
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
    localparam logic [29:0] HALF_Q30      = 30'd536870912;
    localparam logic [29:0] INV_SQRT3_Q30 = 30'd619925131;

    typedef enum logic [1:0] {
        CFG_FRICTION      = 2'd0,
        CFG_MIN_FLOW      = 2'd1,
        CFG_SLIP_SCALE    = 2'd2,
        CFG_PRESSURE_GAIN = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] face;
        logic [7:0]  patch;
    } tags_t;

    // Items that ride alongside the square roots.
    typedef struct packed {
        logic             vm_sat;
        logic [NUM_W-1:0] num;
        tags_t            tags;
    } side_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } root_t;

    // CORDIC angles in units of (pi/2)/2^30.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // exp(-2^(k-16)) in Q.30.
    localparam logic [29:0] EXP_TAB [EXP_BITS] = '{
        30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
        30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
        30'd1069555701, 30'd1065385899, 30'd1057094317, 30'd1040706261,
        30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
        30'd395007536,  30'd145315154,  30'd19666268,   30'd360200,
        30'd121
    };

    // One restoring square root iteration; iteration i tests bit 4^(31-i).
    function automatic root_t root_step(root_t s, int unsigned i);
        logic [63:0] bit_v;
        logic [64:0] trial;
        root_t       r;
        bit_v = 64'd1 << (62 - 2 * i);
        trial = {1'b0, s.res} + {1'b0, bit_v};
        if ({1'b0, s.n} >= trial) begin
            r.n   = s.n - trial[63:0];
            r.res = (s.res >> 1) + bit_v;
        end
        else begin
            r.n   = s.n;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

endpackage

/* hdl/levanov_slip_traction.sv */
// Top level of the Levanov slip traction pipeline: configuration registers,
// flow strength stage, final scaling and output register.
// Depends on lsl_pkg, lsl_front, lsl_root, lsl_divcord and lsl_exptail.
//
// Usage: one contact face is a transfer on the input channel (in_valid and
// in_ready); one traction result per face leaves on the output channel
// (out_valid and out_ready) in the same order, with the face and patch tags
// echoed. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready and writes one of the four registers per transfer.
// The pipeline depth is set by the two-iteration square root stages, the
// paired division and CORDIC stages and the 21 exponential multiply stages.
// Throughput is one face per cycle while the receiver keeps out_ready high.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and in_ready drops; nothing is lost or repeated and bubbles are kept.
// Reset clears every valid bit and loads the register reset values:
// friction factor 0, minimum flow strength 0, slip scale 328, gain 320.
module levanov_slip_traction #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  contact_pressure,
    input  logic signed [31:0]  stress_xx,
    input  logic signed [31:0]  stress_xy,
    input  logic signed [31:0]  stress_xz,
    input  logic signed [31:0]  stress_yy,
    input  logic signed [31:0]  stress_yz,
    input  logic signed [31:0]  stress_zz,
    input  logic signed [31:0]  rel_vel_x,
    input  logic signed [31:0]  rel_vel_y,
    input  logic signed [31:0]  rel_vel_z,
    input  logic [15:0]         face_tag,
    input  logic [7:0]          patch_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [30:0]         slip_traction,
    output logic [15:0]         face_tag_out,
    output logic [7:0]          patch_tag_out,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // Output register of the pipeline.
    logic            out_valid_reg;
    logic [30:0]     out_res_reg;
    lsl_pkg::tags_t  out_tags_reg;

    // Every stage moves together; the output register is the only place a
    // result can wait, so the pipeline advances whenever it is free or taken.
    logic adv;
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    logic [15:0] friction_reg;
    logic [30:0] min_flow_reg;
    logic [30:0] slip_scale_reg;
    logic [15:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            friction_reg   <= 16'd0;
            min_flow_reg   <= 31'd0;
            slip_scale_reg <= 31'd328;
            gain_reg       <= 16'd320;
        end
        else if (cfg_valid)
        begin
            case (lsl_pkg::cfg_idx_t'(cfg_index))
                lsl_pkg::CFG_FRICTION:      friction_reg   <= cfg_data[15:0];
                lsl_pkg::CFG_MIN_FLOW:      min_flow_reg   <= cfg_data[30:0];
                lsl_pkg::CFG_SLIP_SCALE:    slip_scale_reg <= cfg_data[30:0];
                lsl_pkg::CFG_PRESSURE_GAIN: gain_reg       <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    // A slip scale of zero behaves as the smallest step.
    logic [30:0] slip_c;
    assign slip_c = (slip_scale_reg == 31'd0) ? 31'd1 : slip_scale_reg;

    lsl_pkg::tags_t in_tags;
    assign in_tags.face  = face_tag;
    assign in_tags.patch = patch_tag;

    // Squares and sums.
    logic            front_valid;
    logic [63:0]     front_vm2, front_vsq;
    lsl_pkg::side_t  front_side;

    lsl_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (in_valid),
        .contact_pressure (contact_pressure),
        .stress_xx        (stress_xx),
        .stress_xy        (stress_xy),
        .stress_xz        (stress_xz),
        .stress_yy        (stress_yy),
        .stress_yz        (stress_yz),
        .stress_zz        (stress_zz),
        .rel_vel_x        (rel_vel_x),
        .rel_vel_y        (rel_vel_y),
        .rel_vel_z        (rel_vel_z),
        .pressure_gain    (gain_reg),
        .tags             (in_tags),
        .out_valid        (front_valid),
        .vm2              (front_vm2),
        .vsq              (front_vsq),
        .side             (front_side)
    );

    // Von Mises stress and slip speed.
    logic            root_valid;
    logic [30:0]     root_kfvm;
    logic [31:0]     root_vmag;
    lsl_pkg::side_t  root_side;

    lsl_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .vm2       (front_vm2),
        .vsq       (front_vsq),
        .side_in   (front_side),
        .out_valid (root_valid),
        .kf_vm     (root_kfvm),
        .vmag      (root_vmag),
        .side_out  (root_side)
    );

    // Flow strength is the larger of the stress estimate and its floor.
    logic                         kfs_valid_reg;
    logic [30:0]                  kfs_kf_reg;
    logic [31:0]                  kfs_vmag_reg;
    logic [lsl_pkg::NUM_W-1:0]    kfs_num_reg;
    lsl_pkg::tags_t               kfs_tags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kfs_valid_reg <= 1'b0;
        else if (adv)
            kfs_valid_reg <= root_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kfs_kf_reg   <= (min_flow_reg > root_kfvm) ? min_flow_reg : root_kfvm;
            kfs_vmag_reg <= root_vmag;
            kfs_num_reg  <= root_side.num;
            kfs_tags_reg <= root_side.tags;
        end
    end

    // Pressure ratio and slip angle.
    logic                           dc_valid;
    logic [lsl_pkg::DIV_STEPS-1:0]  dc_t;
    logic                           dc_big;
    logic [30:0]                    dc_slip, dc_kf;
    lsl_pkg::tags_t                 dc_tags;

    lsl_divcord #(
        .STEPS (CORDIC_STEPS)
    ) u_divcord (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (kfs_valid_reg),
        .kf        (kfs_kf_reg),
        .num       (kfs_num_reg),
        .vmag      (kfs_vmag_reg),
        .c         (slip_c),
        .tags      (kfs_tags_reg),
        .out_valid (dc_valid),
        .t         (dc_t),
        .t_big     (dc_big),
        .slip      (dc_slip),
        .kf_out    (dc_kf),
        .tags_out  (dc_tags)
    );

    // Pressure factor and scaling by k0 and 1/sqrt(3).
    logic            tail_valid;
    logic [30:0]     tail_m3, tail_kf;
    lsl_pkg::tags_t  tail_tags;

    lsl_exptail u_exptail (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (dc_valid),
        .t               (dc_t),
        .t_big           (dc_big),
        .slip            (dc_slip),
        .kf              (dc_kf),
        .tags            (dc_tags),
        .friction_factor (friction_reg),
        .out_valid       (tail_valid),
        .m3              (tail_m3),
        .kf_out          (tail_kf),
        .tags_out        (tail_tags)
    );

    // Final multiply by the flow strength, rounded and saturated.
    logic [62:0] fin_prod;
    logic [30:0] fin_res;
    assign fin_prod = 63'(tail_m3) * 63'(tail_kf) + 63'(lsl_pkg::HALF_Q30);
    assign fin_res  = (|fin_prod[62:61]) ? lsl_pkg::SAT31 : fin_prod[60:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= tail_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg  <= fin_res;
            out_tags_reg <= tail_tags;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slip_traction = out_res_reg;
    assign face_tag_out  = out_tags_reg.face;
    assign patch_tag_out = out_tags_reg.patch;

`ifndef SYNTHESIS
    // The output register takes whatever the last multiply stage held.
    a_out_follows_tail: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (out_valid_reg == $past(tail_valid)))
        else $error("output valid does not follow the pipeline");

    // A frozen pipeline keeps the last stage occupancy.
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (tail_valid == $past(tail_valid)) && (kfs_valid_reg == $past(kfs_valid_reg)))
        else $error("pipeline moved during a stall");

    // A flow strength floor write lands in its register.
    a_cfg_min_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == lsl_pkg::CFG_MIN_FLOW)
            |=> (min_flow_reg == $past(cfg_data[30:0])))
        else $error("minimum flow strength write lost");
`endif

endmodule

/* hdl/lsl_front.sv */
// Front stages: magnitudes, squares and sums of the stress and velocity terms.
// Depends on lsl_pkg.
module lsl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [31:0]   contact_pressure,
    input  logic signed [31:0]   stress_xx,
    input  logic signed [31:0]   stress_xy,
    input  logic signed [31:0]   stress_xz,
    input  logic signed [31:0]   stress_yy,
    input  logic signed [31:0]   stress_yz,
    input  logic signed [31:0]   stress_zz,
    input  logic signed [31:0]   rel_vel_x,
    input  logic signed [31:0]   rel_vel_y,
    input  logic signed [31:0]   rel_vel_z,
    input  logic [15:0]          pressure_gain,
    input  lsl_pkg::tags_t       tags,
    output logic                 out_valid,
    output logic [63:0]          vm2,
    output logic [63:0]          vsq,
    output lsl_pkg::side_t       side
);

    function automatic logic [31:0] mag_diff(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    logic            v1_reg, v2_reg, v3_reg;
    logic [31:0]     d_reg [3];
    logic [31:0]     a_reg [3];
    logic [31:0]     vel_reg [3];
    logic [31:0]     p_reg;
    lsl_pkg::tags_t  tag1_reg, tag2_reg, tag3_reg;
    logic [63:0]     dsq_reg [3];
    logic [63:0]     asq_reg [3];
    logic [63:0]     vsq_reg [3];
    logic [47:0]     ap_reg;
    logic [63:0]     vm2_reg, vsum_reg;
    logic            sat_reg;
    logic [47:0]     ap3_reg;

    logic [65:0]     dsum;
    logic [67:0]     shear;
    logic [67:0]     vm_sum;
    logic [63:0]     vsum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: absolute values.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0]   <= mag_diff(stress_xx, stress_yy);
            d_reg[1]   <= mag_diff(stress_yy, stress_zz);
            d_reg[2]   <= mag_diff(stress_zz, stress_xx);
            a_reg[0]   <= mag_diff(stress_xy, 32'sd0);
            a_reg[1]   <= mag_diff(stress_xz, 32'sd0);
            a_reg[2]   <= mag_diff(stress_yz, 32'sd0);
            vel_reg[0] <= mag_diff(rel_vel_x, 32'sd0);
            vel_reg[1] <= mag_diff(rel_vel_y, 32'sd0);
            vel_reg[2] <= mag_diff(rel_vel_z, 32'sd0);
            p_reg      <= mag_diff(contact_pressure, 32'sd0);
            tag1_reg   <= tags;
        end
    end

    // Stage two: squares and the gain product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dsq_reg[i] <= 64'(d_reg[i]) * 64'(d_reg[i]);
                asq_reg[i] <= 64'(a_reg[i]) * 64'(a_reg[i]);
                vsq_reg[i] <= 64'(vel_reg[i]) * 64'(vel_reg[i]);
            end
            ap_reg   <= 48'(pressure_gain) * 48'(p_reg);
            tag2_reg <= tag1_reg;
        end
    end

    // Stage three: von Mises square and speed square.
    always_comb
    begin
        dsum      = 66'(dsq_reg[0]) + 66'(dsq_reg[1]) + 66'(dsq_reg[2]);
        shear     = 68'(asq_reg[0]) + 68'(asq_reg[1]) + 68'(asq_reg[2]);
        vm_sum    = 68'(dsum[65:1]) + shear + (shear << 1);
        vsum_next = vsq_reg[0] + vsq_reg[1] + vsq_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vm2_reg  <= {2'b00, vm_sum[61:0]};
            sat_reg  <= |vm_sum[67:62];
            vsum_reg <= vsum_next;
            ap3_reg  <= ap_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign vm2         = vm2_reg;
    assign vsq         = vsum_reg;
    assign side.vm_sat = sat_reg;
    assign side.num    = {ap3_reg, 8'h00};
    assign side.tags   = tag3_reg;

endmodule

/* hdl/lsl_root.sv */
// Two square roots computed in lockstep, two iterations per stage.
// Depends on lsl_pkg.
module lsl_root (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [63:0]     vm2,
    input  logic [63:0]     vsq,
    input  lsl_pkg::side_t  side_in,
    output logic            out_valid,
    output logic [30:0]     kf_vm,
    output logic [31:0]     vmag,
    output lsl_pkg::side_t  side_out
);

    localparam int N = lsl_pkg::ROOT_STAGES;

    logic            v_reg [N];
    lsl_pkg::root_t  a_reg [N];
    lsl_pkg::root_t  b_reg [N];
    lsl_pkg::side_t  s_reg [N];

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic            v_in;
        lsl_pkg::root_t  a_in, b_in, a_n, b_n;
        lsl_pkg::side_t  s_in;

        if (j == 0)
        begin : g_first
            assign v_in = in_valid;
            assign a_in = '{n: vm2, res: 64'd0};
            assign b_in = '{n: vsq, res: 64'd0};
            assign s_in = side_in;
        end
        else
        begin : g_next
            assign v_in = v_reg[j-1];
            assign a_in = a_reg[j-1];
            assign b_in = b_reg[j-1];
            assign s_in = s_reg[j-1];
        end

        always_comb
        begin
            a_n = a_in;
            b_n = b_in;
            for (int s = 0; s < lsl_pkg::ROOT_PER_STAGE; s++)
            begin
                a_n = lsl_pkg::root_step(a_n, j * lsl_pkg::ROOT_PER_STAGE + s);
                b_n = lsl_pkg::root_step(b_n, j * lsl_pkg::ROOT_PER_STAGE + s);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (adv)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg[j] <= a_n;
                b_reg[j] <= b_n;
                s_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign kf_vm     = s_reg[N-1].vm_sat ? lsl_pkg::SAT31 : a_reg[N-1].res[30:0];
    assign vmag      = b_reg[N-1].res[31:0];
    assign side_out  = s_reg[N-1];

endmodule

/* hdl/lsl_divcord.sv */
// Pressure ratio division and slip angle CORDIC, run side by side.
// Depends on lsl_pkg.
module lsl_divcord #(
    parameter int STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [30:0]     kf,
    input  logic [lsl_pkg::NUM_W-1:0] num,
    input  logic [31:0]     vmag,
    input  logic [30:0]     c,
    input  lsl_pkg::tags_t  tags,
    output logic            out_valid,
    output logic [lsl_pkg::DIV_STEPS-1:0] t,
    output logic            t_big,
    output logic [30:0]     slip,
    output logic [30:0]     kf_out,
    output lsl_pkg::tags_t  tags_out
);

    localparam int DIV_ST = (lsl_pkg::DIV_STEPS + 1) / 2;
    localparam int COR_ST = (STEPS + 1) / 2;
    localparam int STAGES = (COR_ST > DIV_ST) ? COR_ST : DIV_ST;
    localparam int CW     = lsl_pkg::CW;
    localparam int ZW     = lsl_pkg::ZW;
    localparam int NW     = lsl_pkg::NUM_W;
    localparam int QW     = lsl_pkg::DIV_STEPS;

    logic                  v_reg   [STAGES+1];
    logic [NW-1:0]         rem_reg [STAGES+1];
    logic [QW-1:0]         q_reg   [STAGES+1];
    logic                  big_reg [STAGES+1];
    logic signed [CW-1:0]  x_reg   [STAGES+1];
    logic signed [CW-1:0]  y_reg   [STAGES+1];
    logic signed [ZW-1:0]  z_reg   [STAGES+1];
    logic [30:0]           kf_reg  [STAGES+1];
    lsl_pkg::tags_t        tag_reg [STAGES+1];

    // Entry stage: the ratio is at least 32 when num reaches kf * 2^21.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            big_reg[0] <= num >= NW'({kf, 21'd0});
            x_reg[0]   <= CW'(c);
            y_reg[0]   <= CW'(vmag);
            z_reg[0]   <= '0;
            kf_reg[0]  <= kf;
            tag_reg[0] <= tags;
        end
    end

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [NW-1:0]        rem_n;
        logic [QW-1:0]        q_n;
        logic signed [CW-1:0] x_n, y_n;
        logic signed [ZW-1:0] z_n;

        always_comb
        begin
            logic signed [CW-1:0] xs, ys;
            logic [NW-1:0]        sub;
            logic                 ge;
            xs    = '0;
            ys    = '0;
            sub   = '0;
            ge    = 1'b0;
            rem_n = rem_reg[j];
            q_n   = q_reg[j];
            x_n   = x_reg[j];
            y_n   = y_reg[j];
            z_n   = z_reg[j];
            for (int s = 0; s < 2; s++)
            begin
                if (2 * j + s < QW)
                begin
                    sub = NW'(kf_reg[j]) << (QW - 1 - (2 * j + s));
                    ge  = rem_n >= sub;
                    if (ge)
                        rem_n = rem_n - sub;
                    q_n = {q_n[QW-2:0], ge};
                end
                if (2 * j + s < STEPS)
                begin
                    xs = x_n >>> (2 * j + s);
                    ys = y_n >>> (2 * j + s);
                    if (y_n > 0)
                    begin
                        x_n = x_n + ys;
                        y_n = y_n - xs;
                        z_n = z_n + $signed({1'b0, lsl_pkg::ATAN_TAB[2 * j + s]});
                    end
                    else
                    begin
                        x_n = x_n - ys;
                        y_n = y_n + xs;
                        z_n = z_n - $signed({1'b0, lsl_pkg::ATAN_TAB[2 * j + s]});
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (adv)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1] <= rem_n;
                q_reg[j+1]   <= q_n;
                big_reg[j+1] <= big_reg[j];
                x_reg[j+1]   <= x_n;
                y_reg[j+1]   <= y_n;
                z_reg[j+1]   <= z_n;
                kf_reg[j+1]  <= kf_reg[j];
                tag_reg[j+1] <= tag_reg[j];
            end
        end
    end

    // The angle is clamped to the first quadrant.
    always_comb
    begin
        if (z_reg[STAGES] < 0)
            slip = '0;
        else if (z_reg[STAGES] > $signed(ZW'(lsl_pkg::ONE_Q30)))
            slip = lsl_pkg::ONE_Q30;
        else
            slip = z_reg[STAGES][30:0];
    end

    assign out_valid = v_reg[STAGES];
    assign t         = q_reg[STAGES];
    assign t_big     = big_reg[STAGES];
    assign kf_out    = kf_reg[STAGES];
    assign tags_out  = tag_reg[STAGES];

endmodule

/* hdl/lsl_exptail.sv */
// Exponential product chain, pressure factor and the scaling multiplies.
// Depends on lsl_pkg.
module lsl_exptail (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [lsl_pkg::DIV_STEPS-1:0] t,
    input  logic            t_big,
    input  logic [30:0]     slip,
    input  logic [30:0]     kf,
    input  lsl_pkg::tags_t  tags,
    input  logic [15:0]     friction_factor,
    output logic            out_valid,
    output logic [30:0]     m3,
    output logic [30:0]     kf_out,
    output lsl_pkg::tags_t  tags_out
);

    localparam int NE = lsl_pkg::EXP_BITS;
    localparam int QW = lsl_pkg::DIV_STEPS;

    logic            v_reg    [NE];
    logic [30:0]     e_reg    [NE];
    logic [QW-1:0]   t_reg    [NE];
    logic            big_reg  [NE];
    logic [30:0]     slip_reg [NE];
    logic [30:0]     kf_reg   [NE];
    lsl_pkg::tags_t  tag_reg  [NE];

    for (genvar j = 0; j < NE; j++)
    begin : g_exp
        logic            v_in, big_in;
        logic [30:0]     e_in, slip_in, kf_in, e_n;
        logic [QW-1:0]   t_in;
        lsl_pkg::tags_t  tag_in;
        logic [60:0]     prod;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign e_in    = lsl_pkg::ONE_Q30;
            assign t_in    = t;
            assign big_in  = t_big;
            assign slip_in = slip;
            assign kf_in   = kf;
            assign tag_in  = tags;
        end
        else
        begin : g_next
            assign v_in    = v_reg[j-1];
            assign e_in    = e_reg[j-1];
            assign t_in    = t_reg[j-1];
            assign big_in  = big_reg[j-1];
            assign slip_in = slip_reg[j-1];
            assign kf_in   = kf_reg[j-1];
            assign tag_in  = tag_reg[j-1];
        end

        assign prod = 61'(e_in) * 61'(lsl_pkg::EXP_TAB[j]) + 61'(lsl_pkg::HALF_Q30);
        assign e_n  = t_in[j] ? prod[60:30] : e_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (adv)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                e_reg[j]    <= e_n;
                t_reg[j]    <= t_in;
                big_reg[j]  <= big_in;
                slip_reg[j] <= slip_in;
                kf_reg[j]   <= kf_in;
                tag_reg[j]  <= tag_in;
            end
        end
    end

    logic            v1_reg, v2_reg, v3_reg;
    logic [30:0]     m1_reg, m2_reg, m3_reg;
    logic [30:0]     kf1_reg, kf2_reg, kf3_reg;
    lsl_pkg::tags_t  tag1_reg, tag2_reg, tag3_reg;
    logic [30:0]     pres;
    logic [61:0]     p1;
    logic [46:0]     p2;
    logic [60:0]     p3;

    // Past a ratio of 32 the exponential is taken as zero.
    assign pres = lsl_pkg::ONE_Q30 - (big_reg[NE-1] ? 31'd0 : e_reg[NE-1]);
    assign p1   = 62'(slip_reg[NE-1]) * 62'(pres) + 62'(lsl_pkg::HALF_Q30);
    assign p2   = 47'(m1_reg) * 47'(friction_factor) + 47'(1 << 14);
    assign p3   = 61'(m2_reg) * 61'(lsl_pkg::INV_SQRT3_Q30) + 61'(lsl_pkg::HALF_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v_reg[NE-1];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg   <= p1[60:30];
            kf1_reg  <= kf_reg[NE-1];
            tag1_reg <= tag_reg[NE-1];
            m2_reg   <= p2[45:15];
            kf2_reg  <= kf1_reg;
            tag2_reg <= tag1_reg;
            m3_reg   <= p3[60:30];
            kf3_reg  <= kf2_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign m3        = m3_reg;
    assign kf_out    = kf3_reg;
    assign tags_out  = tag3_reg;

endmodule

/* test/levanov_slip_traction_tb.sv */
// Self-checking testbench of the slip traction pipeline: directed tables, then
// random faces across several register settings, checked against a predictor.
// Depends on lsl_pkg and levanov_slip_traction.
module levanov_slip_traction_tb;

    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY      = 70;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_FACES = 1900;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    // One contact face, in the order of the input ports.
    typedef struct packed {
        logic signed [31:0] p;
        logic signed [31:0] sxx;
        logic signed [31:0] sxy;
        logic signed [31:0] sxz;
        logic signed [31:0] syy;
        logic signed [31:0] syz;
        logic signed [31:0] szz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        face;
        logic [7:0]         patch;
    } face_t;

    typedef struct {
        face_t       f;
        bit          known;
        logic [30:0] traction;
    } row_t;

    typedef struct {
        logic [30:0] traction;
        logic [15:0] face;
        logic [7:0]  patch;
    } traction_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    face_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [30:0] slip_traction;
    logic [15:0] face_tag_out;
    logic [7:0] patch_tag_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // The typed-in expectation travels with the payload that carries it.
    bit cur_known = 1'b0;
    logic [30:0] cur_traction = '0;
    bit out_no_idle = 1'b0;
    bit in_no_idle = 1'b0;

    // Shadow copy of the configuration registers.
    logic [15:0] k0_reg = 16'd0;
    logic [30:0] kf0_reg = 31'd0;
    logic [30:0] c_reg = 31'd328;
    logic [15:0] gain_reg = 16'd320;

    traction_t pending_tractions[$];
    int errors = 0;
    int cycles = 0;

    // Reset config: k0 is zero, so every traction is zero.
    row_t reset_rows[6] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, 32'sd0, 16'd0, 8'd0}, 1'b1, 31'd0},
        '{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX,
            SMAX, SMAX, SMAX, 16'hFFFF, 8'hFF}, 1'b1, 31'd0},
        '{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN,
            SMIN, SMIN, SMIN, 16'h0001, 8'h01}, 1'b1, 31'd0},
        '{'{32'sd25600, SMAX, 32'sd0, 32'sd0, SMIN, 32'sd0, 32'sd0,
            32'sd65536, 32'sd0, 32'sd0, 16'h5555, 8'hAA}, 1'b1, 31'd0},
        '{'{-32'sd256, 32'sd1000, 32'sd5, -32'sd7, 32'sd12, 32'sd99, -32'sd300,
            32'sd328, -32'sd328, 32'sd1, 16'hAAAA, 8'h55}, 1'b1, 31'd0},
        '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, 32'sd0, 16'h8000, 8'h80}, 1'b1, 31'd0}
    };

    // Full-scale config, slip scale zero (taken as one).
    row_t scale_rows[9] = '{
        // Zero flow strength gives a zero traction.
        '{'{SMAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            SMAX, SMAX, SMAX, 16'd1, 8'd2}, 1'b1, 31'd0},
        // Huge von Mises stress saturates the flow strength.
        '{'{SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN,
            SMAX, 32'sd0, 32'sd0, 16'd3, 8'd4}, 1'b0, 31'd0},
        '{'{SMIN, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX,
            SMIN, SMIN, SMIN, 16'd5, 8'd6}, 1'b0, 31'd0},
        // Zero slip velocity.
        '{'{32'sd25600, 32'sd25600, 32'sd100, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, 32'sd0, 16'd7, 8'd8}, 1'b0, 31'd0},
        // Large pressure ratio drives the exponential to zero.
        '{'{SMAX, 32'sd256, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd65536, 32'sd0, 32'sd0, 16'd9, 8'd10}, 1'b0, 31'd0},
        '{'{32'sd1, SMAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd1, 32'sd1, 32'sd1, 16'd11, 8'd12}, 1'b0, 31'd0},
        '{'{-32'sd5000, 32'sd3000, -32'sd2000, 32'sd1000, -32'sd4000, 32'sd7, 32'sd9,
            -32'sd100, 32'sd200, -32'sd300, 16'd13, 8'd14}, 1'b0, 31'd0},
        '{'{32'sd256, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, SMAX,
            32'sd0, SMIN, 32'sd0, 16'd15, 8'd16}, 1'b0, 31'd0},
        '{'{32'sd70000, 32'sd0, SMAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, SMAX, 16'd17, 8'd18}, 1'b0, 31'd0}
    };

    levanov_slip_traction #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .contact_pressure(cur.p),
        .stress_xx(cur.sxx), .stress_xy(cur.sxy), .stress_xz(cur.sxz),
        .stress_yy(cur.syy), .stress_yz(cur.syz), .stress_zz(cur.szz),
        .rel_vel_x(cur.vx), .rel_vel_y(cur.vy), .rel_vel_z(cur.vz),
        .face_tag(cur.face), .patch_tag(cur.patch),
        .out_valid(out_valid), .out_ready(out_ready),
        .slip_traction(slip_traction), .face_tag_out(face_tag_out),
        .patch_tag_out(patch_tag_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Traction of one face under the shadow configuration.
    function automatic logic [30:0] predict_traction(face_t f);
        logic [63:0] d1, d2, d3, a1, a2, a3, dsum, shear, vm2, kfvm, kf;
        logic [63:0] vmag, t, e, pres, m;
        longint x, y, z, xs, ys;
        d1 = mag(longint'(f.sxx) - longint'(f.syy));
        d2 = mag(longint'(f.syy) - longint'(f.szz));
        d3 = mag(longint'(f.szz) - longint'(f.sxx));
        a1 = mag(longint'(f.sxy));
        a2 = mag(longint'(f.sxz));
        a3 = mag(longint'(f.syz));
        // The 64-bit squares cannot wrap; the sum saturates.
        dsum = sat_add(sat_add(d1 * d1, d2 * d2), d3 * d3) >> 1;
        shear = a1 * a1 + a2 * a2 + a3 * a3;
        shear = (shear > 64'hFFFF_FFFF_FFFF_FFFF / 3) ? 64'hFFFF_FFFF_FFFF_FFFF : shear * 3;
        vm2 = sat_add(dsum, shear);
        kfvm = (vm2 >= (64'd1 << 62)) ? 64'(lsl_pkg::SAT31) : int_sqrt(vm2);
        kf = (64'(kf0_reg) > kfvm) ? 64'(kf0_reg) : kfvm;
        if (kf == 0)
            return 31'd0;
        vmag = int_sqrt(mag(f.vx) * mag(f.vx) + mag(f.vy) * mag(f.vy)
                        + mag(f.vz) * mag(f.vz));
        x = (c_reg == 0) ? 64'sd1 : longint'(c_reg);
        y = longint'(vmag);
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(lsl_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(lsl_pkg::ATAN_TAB[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(lsl_pkg::ONE_Q30))
            z = longint'(lsl_pkg::ONE_Q30);
        t = ((64'(gain_reg) * mag(f.p)) << 8) / kf;
        e = 64'(lsl_pkg::ONE_Q30);
        if (t >= (64'd1 << 21))
            e = '0;
        else
            for (int k = 0; k < lsl_pkg::EXP_BITS; k++)
                if (t[k])
                    e = (e * 64'(lsl_pkg::EXP_TAB[k]) + 64'(lsl_pkg::HALF_Q30)) >> 30;
        pres = 64'(lsl_pkg::ONE_Q30) - e;
        m = (64'(z) * pres + 64'(lsl_pkg::HALF_Q30)) >> 30;
        m = (m * 64'(k0_reg) + (64'd1 << 14)) >> 15;
        m = (m * 64'(lsl_pkg::INV_SQRT3_Q30) + 64'(lsl_pkg::HALF_Q30)) >> 30;
        m = (m * kf + 64'(lsl_pkg::HALF_Q30)) >> 30;
        return (m > 64'(lsl_pkg::SAT31)) ? lsl_pkg::SAT31 : m[30:0];
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Every transfer is seen here: inputs at acceptance, results on arrival.
    always @(posedge clk)
    begin
        traction_t want;
        if (rst_n && in_valid && in_ready)
        begin
            want.traction = cur_known ? cur_traction : predict_traction(cur);
            want.face = cur.face;
            want.patch = cur.patch;
            pending_tractions.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tractions.size() == 0)
            begin
                report("unexpected result", 32'(slip_traction), 32'd0);
            end
            else
            begin
                want = pending_tractions.pop_front();
                if (slip_traction !== want.traction)
                    report("slip_traction", 32'(slip_traction), 32'(want.traction));
                if (face_tag_out !== want.face)
                    report("face_tag_out", 32'(face_tag_out), 32'(want.face));
                if (patch_tag_out !== want.patch)
                    report("patch_tag_out", 32'(patch_tag_out), 32'(want.patch));
            end
        end
    end

    // The receiver stalls at random; out_ready gets one assignment per step.
    always @(negedge clk)
    begin
        static int stall = 0;
        logic ready_next;
        if (stall > 0)
        begin
            stall--;
            ready_next = 1'b0;
        end
        else
        begin
            stall = idle_gap(out_no_idle);
            ready_next = (stall == 0);
        end
        out_ready <= ready_next;
    end

    // A runaway run ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** levanov_slip_traction: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(lsl_pkg::cfg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lsl_pkg::CFG_FRICTION:      k0_reg = value[15:0];
            lsl_pkg::CFG_MIN_FLOW:      kf0_reg = value[30:0];
            lsl_pkg::CFG_SLIP_SCALE:    c_reg = value[30:0];
            lsl_pkg::CFG_PRESSURE_GAIN: gain_reg = value[15:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Leaves at the rising edge of the transfer; the caller moves on from there.
    task automatic send_face(face_t f, bit known, logic [30:0] traction);
        int gap;
        gap = idle_gap(in_no_idle);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cur <= f;
        cur_known <= known;
        cur_traction <= traction;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tractions.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 6))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 8191)) - 4096;
            2:       return $signed($urandom_range(0, 2097151)) - 1048576;
            3:       return $urandom_range(0, 1) ? SMAX : SMIN;
            4:       return 32'sd0;
            5:       return $signed($urandom) >>> $urandom_range(0, 31);
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic logic [31:0] rand_reg(int width);
        logic [31:0] hi;
        hi = (width == 16) ? 32'h0000_FFFF : 32'h7FFF_FFFF;
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return hi;
            2:       return $urandom_range(0, 2000);
            default: return $urandom & hi;
        endcase
    endfunction

    initial
    begin
        face_t f;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Values after reset: a zero friction factor makes every traction zero.
        foreach (reset_rows[i])
            send_face(reset_rows[i].f, reset_rows[i].known, reset_rows[i].traction);
        drain_pipeline();

        write_reg(lsl_pkg::CFG_FRICTION, 32'h0000_FFFF);
        write_reg(lsl_pkg::CFG_MIN_FLOW, 32'd0);
        write_reg(lsl_pkg::CFG_SLIP_SCALE, 32'd0);
        write_reg(lsl_pkg::CFG_PRESSURE_GAIN, 32'h0000_FFFF);
        foreach (scale_rows[i])
            send_face(scale_rows[i].f, scale_rows[i].known, scale_rows[i].traction);
        drain_pipeline();

        // Random phases, each under a fresh setting; phases 0 and 1 use extremes.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(lsl_pkg::CFG_FRICTION, 32'd32768);
                    write_reg(lsl_pkg::CFG_MIN_FLOW, 32'h7FFF_FFFF);
                    write_reg(lsl_pkg::CFG_SLIP_SCALE, 32'h7FFF_FFFF);
                    write_reg(lsl_pkg::CFG_PRESSURE_GAIN, 32'd0);
                end
                1:
                begin
                    write_reg(lsl_pkg::CFG_FRICTION, 32'd65535);
                    write_reg(lsl_pkg::CFG_MIN_FLOW, 32'd1);
                    write_reg(lsl_pkg::CFG_SLIP_SCALE, 32'd1);
                    write_reg(lsl_pkg::CFG_PRESSURE_GAIN, 32'd65535);
                end
                2:
                begin
                    write_reg(lsl_pkg::CFG_FRICTION, 32'd20000);
                    write_reg(lsl_pkg::CFG_MIN_FLOW, 32'd25600);
                    write_reg(lsl_pkg::CFG_SLIP_SCALE, 32'd328);
                    write_reg(lsl_pkg::CFG_PRESSURE_GAIN, 32'd320);
                end
                default:
                begin
                    write_reg(lsl_pkg::CFG_FRICTION, rand_reg(16));
                    write_reg(lsl_pkg::CFG_MIN_FLOW, rand_reg(31));
                    write_reg(lsl_pkg::CFG_SLIP_SCALE, rand_reg(31));
                    write_reg(lsl_pkg::CFG_PRESSURE_GAIN, rand_reg(16));
                end
            endcase
            // Some phases run without any idling on one or both sides.
            in_no_idle = (phase == 3 || phase == 5);
            out_no_idle = (phase == 3 || phase == 6);
            for (int n = 0; n < RANDOM_FACES / 8; n++)
            begin
                f.p = rand_word();
                f.sxx = rand_word();
                f.sxy = rand_word();
                f.sxz = rand_word();
                f.syy = rand_word();
                f.syz = rand_word();
                f.szz = rand_word();
                f.vx = rand_word();
                f.vy = rand_word();
                f.vz = rand_word();
                f.face = 16'($urandom);
                f.patch = 8'($urandom);
                send_face(f, 1'b0, 31'd0);
            end
            in_no_idle = 1'b0;
            out_no_idle = 1'b0;
            drain_pipeline();
        end

        if (errors == 0)
            $display("** levanov_slip_traction: PASSED **");
        else
            $display("** levanov_slip_traction: FAILED **");
        $finish;
    end

endmodule
